FILE: hw/rtl/hem_pkg.sv
`timescale 1ns / 1ps
package hem_pkg;

    localparam int unsigned MAX_FRAME_PIXELS = 4194304;
    localparam int unsigned GREY_LEVELS      = 256;
    localparam int unsigned CNT_W            = 23;
    localparam int unsigned PIX_W            = 8;
    localparam int unsigned NUM_W            = 32;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_BLD,
        ST_MAP_ADR,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: hw/rtl/hem_front.sv
`timescale 1ns / 1ps
module hem_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hem_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output hem_pkg::item_t  q_item
);
    import hem_pkg::*;

    item_t              fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               push, pop;

    assign in_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    // drop the unused command here so the back end never sees it
    assign push     = in_valid && in_ready && (in_item.cmd != CMD_NONE);
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/hem_back.sv
`timescale 1ns / 1ps
module hem_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hem_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  hem_pkg::item_t            q_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [hem_pkg::PIX_W-1:0] out_data
);
    import hem_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);
    localparam logic [PIX_W-1:0] TOP     = PIX_W'(GREY_LEVELS - 1);
    localparam logic [PIX_W-1:0] LAST    = PIX_W'(GREY_LEVELS - 1);

    logic [CNT_W-1:0]       bin_mem [GREY_LEVELS];
    logic [CNT_W-1:0]       cdf_mem [GREY_LEVELS];
    logic [CNT_W-1:0]       bin_rd_reg, cdf_rd_reg;

    state_t                 state_reg, state_next;
    logic [GREY_LEVELS-1:0] bin_valid_reg, bin_valid_next;
    logic                   ready_reg, ready_next;
    logic [CNT_W-1:0]       fp_reg;
    logic [PIX_W-1:0]       pix_reg, pix_next;
    logic [PIX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       sum_reg, sum_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [CNT_W:0]         den_reg, den_next;
    logic [PIX_W-1:0]       quo_reg, quo_next;
    logic [2:0]             step_reg, step_next;
    logic [PIX_W-1:0]       res_reg, res_next;

    logic [PIX_W-1:0]       bin_raddr;
    logic                   bin_we, cdf_we;
    logic [PIX_W-1:0]       bin_waddr, cdf_waddr;
    logic [CNT_W-1:0]       bin_wdata, cdf_wdata;
    logic [CNT_W-1:0]       fp_eff, bin_cur;
    logic [CNT_W:0]         sum_wide;
    logic [NUM_W-1:0]       trial;

    always_comb
    begin
        priority if (fp_reg == '0)
            fp_eff = CNT_W'(1);
        else if (fp_reg > MAX_CNT)
            fp_eff = MAX_CNT;
        else
            fp_eff = fp_reg;
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        bin_valid_next = bin_valid_reg;
        ready_next     = ready_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        q_ready        = 1'b0;
        bin_raddr      = q_item.pixel;
        bin_we         = 1'b0;
        bin_waddr      = pix_reg;
        bin_wdata      = '0;
        cdf_we         = 1'b0;
        cdf_waddr      = idx_reg;
        cdf_wdata      = '0;
        bin_cur        = bin_valid_reg[idx_reg] ? bin_rd_reg : '0;
        sum_wide       = {1'b0, sum_reg} + {1'b0, bin_cur};
        trial          = NUM_W'({den_reg, 7'b0} >> (3'd7 - step_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = q_valid;
                if (q_valid)
                begin
                    pix_next = q_item.pixel;
                    unique case (q_item.cmd)
                        CMD_CLEAR:
                        begin
                            bin_valid_next = '0;
                            ready_next     = 1'b0;
                        end
                        CMD_COUNT:
                        begin
                            ready_next = 1'b0;
                            state_next = ST_CNT_RD;
                        end
                        CMD_MAP:
                        begin
                            if (ready_reg)
                                state_next = ST_MAP_ADR;
                            else
                            begin
                                bin_raddr  = '0;
                                idx_next   = '0;
                                sum_next   = '0;
                                state_next = ST_BLD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CNT_RD:
            begin
                // bin word for pix_reg has arrived; saturate and write back
                bin_cur   = bin_valid_reg[pix_reg] ? bin_rd_reg : '0;
                bin_we    = 1'b1;
                bin_wdata = (bin_cur < MAX_CNT) ? bin_cur + 1'b1 : bin_cur;
                bin_valid_next[pix_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BLD:
            begin
                cdf_we    = 1'b1;
                cdf_wdata = (sum_wide > {1'b0, MAX_CNT}) ? MAX_CNT : sum_wide[CNT_W-1:0];
                sum_next  = cdf_wdata;
                bin_raddr = idx_reg + 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    ready_next = 1'b1;
                    state_next = ST_MAP_ADR;
                end
            end
            ST_MAP_ADR:
            begin
                state_next = ST_MAP_MUL;
            end
            ST_MAP_MUL:
            begin
                if (cdf_rd_reg >= fp_eff)
                begin
                    res_next   = TOP;
                    state_next = ST_OUT;
                end
                else
                begin
                    // cdf below frame size, so the quotient fits in one byte
                    num_next   = NUM_W'(cdf_rd_reg) * NUM_W'(2 * (GREY_LEVELS - 1))
                                 + NUM_W'(fp_eff);
                    den_next   = {fp_eff, 1'b0};
                    quo_next   = '0;
                    step_next  = 3'd7;
                    state_next = ST_MAP_DIV;
                end
            end
            ST_MAP_DIV:
            begin
                if (num_reg >= trial)
                begin
                    num_next           = num_reg - trial;
                    quo_next[step_reg] = 1'b1;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == 3'd0)
                begin
                    res_next   = quo_next;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_valid_reg <= '0;
            ready_reg     <= 1'b0;
            fp_reg        <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            bin_valid_reg <= bin_valid_next;
            ready_reg     <= ready_next;
            if (cfg_we)
                fp_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        bin_rd_reg <= bin_mem[bin_raddr];
        if (bin_we)
            bin_mem[bin_waddr] <= bin_wdata;
    end

    always_ff @(posedge clk)
    begin
        cdf_rd_reg <= cdf_mem[pix_reg];
        if (cdf_we)
            cdf_mem[cdf_waddr] <= cdf_wdata;
    end

endmodule

FILE: hw/rtl/histogram_equalizer_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata[7:0] pixel, tuser[1:0] command
// m_*       out  m_tvalid/m_tready  tdata[7:0] mapped_pixel
// cfg_*     in   cfg_we             cfg_wdata[22:0] frame_pixels
//
// In the back end a clear needs no extra state; a count reads, then writes, the bin memory.
// A map passes through address, multiply and divide states, then holds its result
// until m_tready; the serial divider finds the eight quotient bits one at a time.
// A map whose answer saturates skips the divider. The first map after a clear or
// count first sweeps the bin memory into the cumulative table.
// Reset clears the histogram at once through per-bin valid flags.
// A 4-word queue lets s_* keep taking words while a result waits on m_*.
module histogram_equalizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] mapped_pixel
    input  logic        cfg_we,
    input  logic [22:0] cfg_wdata
);
    import hem_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.cmd   = cmd_t'(s_tuser);
    assign in_item.pixel = s_tdata;

    hem_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    hem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // no new command is taken while a result is pending
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !q_ready)
        else $error("command taken while result pending");

    // a result never follows straight after taking a command
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> !m_tvalid)
        else $error("result too early");

    // the back end only takes words the queue offers
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid)
        else $error("take without queued word");

endmodule
